>>> src/bmpu_pkg.sv
// ----------------------------------------------------------------------------
// BMP palette unpacker package
// Shared widths, register indexes and the dimension clamp.
// ----------------------------------------------------------------------------
package bmpu_pkg;

    // Configuration register width and frame dimension width
    localparam int DIM_W = 13;

    // Payload widths
    localparam int SLOT_W  = 8;
    localparam int COLOR_W = 32;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 24;

    // Packed stream widths (whole bytes)
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_MAX_HEIGHT    = 4096;
    localparam int DEF_PALETTE_DEPTH = 256;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_cfg_reg;

    // Input item kinds (tuser)
    typedef enum logic [0:0] {
        ACT_PALETTE = 1'b0,
        ACT_PIXEL   = 1'b1
    } t_action;

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned maxv);
        logic [31:0] v_ext;
        logic [DIM_W-1:0] res;
        v_ext = 32'(v);
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v_ext > maxv) begin
            res = DIM_W'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

>>> src/bmp_palette_pixel_unpacker.sv
// ----------------------------------------------------------------------------
// BMP 8 bpp palette pixel unpacker
// Looks up raw pixel-array bytes in a 32-bit palette and emits top-down
// frame addresses, dropping the row padding bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser selects the request kind. A palette request
//   (tuser 0) writes tdata's color word into a palette slot. A pixel request
//   (tuser 1) carries one pixel-array byte in file order, bottom row first.
//   Output stream (m_axis): one request per pixel with its top-down address
//   (row * width + column) and palette color; tlast marks the frame's final
//   pixel. Padding bytes at each row end and palette writes give no output.
//   The palette read is registered in stage 1, and the address multiply feeds
//   the output register. Throughput is one request per cycle while the
//   receiver does not stall, set by the single-port palette memory and a
//   13x13 multiplier, both used once per request.
//   Configuration: width and height are written through the plain write port
//   while the block is idle; any write restarts the frame.
//   Reset sets width and height to 1 and restarts the frame; palette contents
//   are undefined until written. When the receiver stalls, the output
//   register holds, the pipeline freezes and s_axis_tready drops.
// ----------------------------------------------------------------------------
module bmp_palette_pixel_unpacker #(
    parameter int MAX_WIDTH     = bmpu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = bmpu_pkg::DEF_MAX_HEIGHT,
    parameter int PALETTE_DEPTH = bmpu_pkg::DEF_PALETTE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_index,
    input  logic [bmpu_pkg::DIM_W-1:0]      i_cfg_data,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: palette_slot[7:0], palette_color[39:8], data_byte[47:40]
    input  logic [bmpu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: action[0]
    input  logic [0:0]                      s_axis_tuser,
    // Output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: pixel_address[23:0], pixel_color[55:24]
    output logic [bmpu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tlast: frame_last
    output logic                            m_axis_tlast
);

    localparam int DW = bmpu_pkg::DIM_W;
    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = bmpu_pkg::COLOR_W;

    // Input field unpack
    logic [bmpu_pkg::SLOT_W-1:0]  w_slot;
    logic [CW-1:0]                w_color;
    logic [bmpu_pkg::BYTE_W-1:0]  w_byte;
    logic                         w_is_pixel;

    assign w_slot     = s_axis_tdata[7:0];
    assign w_color    = s_axis_tdata[39:8];
    assign w_byte     = s_axis_tdata[47:40];
    assign w_is_pixel = (s_axis_tuser == bmpu_pkg::ACT_PIXEL);

    // Frame state
    logic [DW-1:0] r_eff_w, n_eff_w;
    logic [DW-1:0] r_eff_h, n_eff_h;
    logic [DW-1:0] r_col, n_col;
    logic [DW-1:0] r_row, n_row;
    logic [1:0]    r_pad, n_pad;

    // Pipeline stage 1 (palette read in flight) and output register
    logic          r_s1_valid, n_s1_valid;
    logic [DW-1:0] r_s1_col;
    logic [DW-1:0] r_s1_row;
    logic          r_s1_last;
    logic          r_s1_oob;
    logic [CW-1:0] r_rd_data;

    logic                           r_out_valid;
    logic [bmpu_pkg::ADDR_W-1:0]    r_out_addr;
    logic [CW-1:0]                  r_out_color;
    logic                           r_out_last;

    logic [CW-1:0] r_palette [PALETTE_DEPTH];

    // Whole pipeline advances when the output register is free or drained
    logic w_adv;
    logic w_accept;
    logic w_pix_emit;
    logic w_row_end;
    logic w_frame_end;
    logic [DW-1:0] w_col_inc;
    logic w_slot_ok;
    logic w_byte_ok;
    logic [2*DW-1:0] w_addr_full;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_accept      = s_axis_tvalid && w_adv;
    assign w_pix_emit    = w_accept && w_is_pixel && (r_pad == 2'd0);
    assign w_col_inc     = r_col + DW'(1);
    assign w_row_end     = (w_col_inc == r_eff_w);
    assign w_frame_end   = w_row_end && (r_row == '0);
    assign w_slot_ok     = ({1'b0, w_slot} < 9'(PALETTE_DEPTH));
    assign w_byte_ok     = ({1'b0, w_byte} < 9'(PALETTE_DEPTH));

    // Counter and configuration next state
    always_comb begin
        n_eff_w    = r_eff_w;
        n_eff_h    = r_eff_h;
        n_col      = r_col;
        n_row      = r_row;
        n_pad      = r_pad;
        n_s1_valid = w_adv ? w_pix_emit : r_s1_valid;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                bmpu_pkg::REG_WIDTH: begin
                    n_eff_w = bmpu_pkg::clamp_dim(i_cfg_data, MAX_WIDTH);
                end
                bmpu_pkg::REG_HEIGHT: begin
                    n_eff_h = bmpu_pkg::clamp_dim(i_cfg_data, MAX_HEIGHT);
                end
                default: begin
                    n_eff_w = r_eff_w;
                end
            endcase
            n_col = '0;
            n_row = n_eff_h - DW'(1);
            n_pad = 2'd0;
        end else if (w_accept && w_is_pixel) begin
            if (r_pad != 2'd0) begin
                // Padding byte: drop it
                n_pad = r_pad - 2'd1;
            end else if (w_row_end) begin
                n_col = '0;
                n_pad = 2'(-r_eff_w);
                n_row = w_frame_end ? (r_eff_h - DW'(1)) : (r_row - DW'(1));
            end else begin
                n_col = w_col_inc;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w     <= DW'(1);
            r_eff_h     <= DW'(1);
            r_col       <= '0;
            r_row       <= '0;
            r_pad       <= 2'd0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_eff_w    <= n_eff_w;
            r_eff_h    <= n_eff_h;
            r_col      <= n_col;
            r_row      <= n_row;
            r_pad      <= n_pad;
            r_s1_valid <= n_s1_valid;
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Palette memory: write on palette requests, registered read on pixels
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_is_pixel && w_slot_ok) begin
            r_palette[w_slot[AW-1:0]] <= w_color;
        end
        if (w_pix_emit && w_byte_ok) begin
            r_rd_data <= r_palette[w_byte[AW-1:0]];
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_last <= w_frame_end;
            r_s1_oob  <= !w_byte_ok;
        end
    end

    // Address multiply at full product width, then the output register
    assign w_addr_full = (2*DW)'(r_s1_row) * (2*DW)'(r_eff_w) + (2*DW)'(r_s1_col);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_addr  <= w_addr_full[bmpu_pkg::ADDR_W-1:0];
            r_out_color <= r_s1_oob ? '0 : r_rd_data;
            r_out_last  <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_color, r_out_addr};
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Column and row counters stay inside the frame
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < r_eff_w)
        else $error("column counter outside frame width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row < r_eff_h)
        else $error("row counter outside frame height");

    // Final pixel of a frame is the last column of the top row
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tdata[23:0] == 24'(r_eff_w - DW'(1))))
        else $error("frame end flagged away from the top-right pixel");

    // A stalled stage 1 holds its position
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> (r_s1_valid && $stable(r_s1_col) && $stable(r_s1_row)))
        else $error("stage 1 changed while stalled");

endmodule

>>> bench/bmp_palette_pixel_unpacker_tb.sv
// ----------------------------------------------------------------------------
// BMP palette pixel unpacker testbench
// Loads palette words and streams pixel-array bytes with random gaps on both
// sides, predicts every emitted pixel in a local palette and frame-counter
// mirror, and compares each output request field by field in order.
// ----------------------------------------------------------------------------
module bmp_palette_pixel_unpacker_tb;
    import bmpu_pkg::*;

    localparam int PAL_DEPTH = DEF_PALETTE_DEPTH;
    localparam int MAX_W     = DEF_MAX_WIDTH;
    localparam int MAX_H     = DEF_MAX_HEIGHT;
    localparam int LATENCY   = 2;
    localparam int DIM_MAX   = (1 << DIM_W) - 1;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel;

    // DUT ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [0:0]            i_cfg_index;
    logic [DIM_W-1:0]      i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Mirror of the block state
    logic [COLOR_W-1:0] pal_mirror [PAL_DEPTH];
    bit                 pal_valid  [PAL_DEPTH];
    logic [SLOT_W-1:0]  pal_loaded [$];
    logic [DIM_W-1:0]   reg_width;
    logic [DIM_W-1:0]   reg_height;
    int unsigned        col_pos;
    int unsigned        row_pos;
    int unsigned        pad_left;
    t_pixel             pending_pixels [$];

    // Run control
    bit                 idle_on;
    int unsigned        rx_hold;
    int unsigned        err_cnt;
    t_pixel             rx_exp;

    bmp_palette_pixel_unpacker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Zero acts as one, oversize acts as the maximum
    function automatic int unsigned active_dim(logic [DIM_W-1:0] v, int unsigned maxv);
        int unsigned d;
        d = v;
        if (d == 0) begin
            d = 1;
        end else if (d > maxv) begin
            d = maxv;
        end
        return d;
    endfunction

    task automatic restart_frame();
        col_pos  = 0;
        row_pos  = active_dim(reg_height, MAX_H) - 1;
        pad_left = 0;
    endtask

    // Predict one accepted request; pixels go to the pending queue
    task automatic decode_request(t_action act, logic [SLOT_W-1:0] slot,
                                  logic [COLOR_W-1:0] color, logic [BYTE_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        t_pixel      p;
        if (act == ACT_PALETTE) begin
            if (!pal_valid[slot]) begin
                pal_valid[slot] = 1'b1;
                pal_loaded.push_back(slot);
            end
            pal_mirror[slot] = color;
        end else if (pad_left != 0) begin
            pad_left--;
        end else begin
            w       = active_dim(reg_width, MAX_W);
            h       = active_dim(reg_height, MAX_H);
            p.addr  = ADDR_W'(row_pos * w + col_pos);
            p.color = pal_mirror[pix];
            p.last  = 1'b0;
            col_pos++;
            // row end: schedule padding, step up the frame
            if (col_pos >= w) begin
                col_pos  = 0;
                pad_left = (4 - w % 4) % 4;
                if (row_pos == 0) begin
                    p.last  = 1'b1;
                    row_pos = h - 1;
                end else begin
                    row_pos--;
                end
            end
            pending_pixels.push_back(p);
        end
    endtask

    // Padding may carry anything; real pixels only index loaded slots
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] b;
        if (pad_left != 0) begin
            b = BYTE_W'($urandom);
        end else begin
            b = pal_loaded[$urandom_range(0, pal_loaded.size() - 1)];
        end
        return b;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(int unsigned maxv);
        int unsigned sel;
        logic [DIM_W-1:0] d;
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
            d = DIM_W'($urandom_range(1, 9));
        end else if (sel < 17) begin
            d = DIM_W'($urandom_range(10, 300));
        end else if (sel == 17) begin
            d = '0;
        end else if (sel == 18) begin
            d = DIM_W'(maxv);
        end else begin
            d = DIM_W'($urandom_range(maxv + 1, DIM_MAX));
        end
        return d;
    endfunction

    // Offer one request, optionally after an idle burst, and wait for accept
    task automatic send_request(t_action act, logic [SLOT_W-1:0] slot,
                                logic [COLOR_W-1:0] color, logic [BYTE_W-1:0] pix);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {pix, color, slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_request(act, slot, color, pix);
    endtask

    task automatic send_palette(logic [SLOT_W-1:0] slot, logic [COLOR_W-1:0] color);
        send_request(ACT_PALETTE, slot, color, BYTE_W'($urandom));
    endtask

    task automatic send_pixel(logic [BYTE_W-1:0] pix);
        send_request(ACT_PIXEL, SLOT_W'($urandom), COLOR_W'($urandom), pix);
    endtask

    // Stop offering, drain all pixels, let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // Write both dimension registers; each write restarts the frame
    task automatic set_frame_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_WIDTH;
        i_cfg_data  <= w;
        @(negedge i_clk);
        i_cfg_index <= REG_HEIGHT;
        i_cfg_data  <= h;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        reg_width  = w;
        reg_height = h;
        restart_frame();
    endtask

    // Receiver: random stalls plus a long hold requested by a test
    initial begin : rx_driver
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold != 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare every accepted pixel with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel: address %0d color %h last %0b",
                       m_axis_tdata[ADDR_W-1:0], m_axis_tdata[ADDR_W +: COLOR_W],
                       m_axis_tlast);
                err_cnt++;
            end else begin
                rx_exp = pending_pixels.pop_front();
                if (m_axis_tdata[ADDR_W-1:0] !== rx_exp.addr) begin
                    $error("pixel_address: expected %0d, actual %0d",
                           rx_exp.addr, m_axis_tdata[ADDR_W-1:0]);
                    err_cnt++;
                end
                if (m_axis_tdata[ADDR_W +: COLOR_W] !== rx_exp.color) begin
                    $error("pixel_color: expected %h, actual %h",
                           rx_exp.color, m_axis_tdata[ADDR_W +: COLOR_W]);
                    err_cnt++;
                end
                if (m_axis_tlast !== rx_exp.last) begin
                    $error("frame_last: expected %0b, actual %0b",
                           rx_exp.last, m_axis_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Reset size 1x1: every pixel ends the frame, three pad bytes follow
    task automatic test_reset_defaults();
        send_palette(8'h00, 32'hFFFF_FFFF);
        send_palette(8'hFF, 32'h0000_0000);
        send_palette(8'h55, 32'hA5A5_5A5A);
        send_palette(8'hAA, 32'h5A5A_A5A5);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h3C);
        send_pixel(8'hFF);
        send_pixel(pick_byte());
        send_pixel(pick_byte());
        send_pixel(pick_byte());
        send_pixel(8'h55);
    endtask

    // Zero and oversize dimensions, the largest frame, restart mid-frame
    task automatic test_dim_limits();
        settle();
        set_frame_size('0, DIM_W'(DIM_MAX));
        send_pixel(8'hAA);
        send_pixel(pick_byte());
        send_pixel(pick_byte());
        send_pixel(pick_byte());
        send_pixel(8'h55);
        settle();
        set_frame_size(DIM_W'(DIM_MAX), '0);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        settle();
        set_frame_size(DIM_W'(MAX_W), DIM_W'(MAX_H));
        send_pixel(8'hAA);
        send_pixel(8'h55);
    endtask

    // 3x2 frame: one pad byte per row, last flag on the final pixel
    task automatic test_row_padding();
        settle();
        set_frame_size(DIM_W'(3), DIM_W'(2));
        repeat (2) begin
            repeat (3) send_pixel(pick_byte());
            send_pixel(pick_byte());
        end
        send_pixel(pick_byte());
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        settle();
        set_frame_size(DIM_W'(5), DIM_W'(3));
        rx_hold = 400;
        repeat (60) send_pixel(pick_byte());
        settle();
    endtask

    // Random frame sizes; mostly pixel streams, some palette updates
    task automatic test_random_frames(int unsigned phases, int unsigned per_phase);
        repeat (phases) begin
            settle();
            set_frame_size(pick_dim(MAX_W), pick_dim(MAX_H));
            repeat (per_phase) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_palette(SLOT_W'($urandom), COLOR_W'($urandom));
                end else begin
                    send_pixel(pick_byte());
                end
            end
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_WIDTH;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_PALETTE;
        m_axis_tready = 1'b0;
        idle_on       = 1'b1;
        rx_hold       = 0;
        err_cnt       = 0;
        reg_width     = DIM_W'(1);
        reg_height    = DIM_W'(1);
        for (int i = 0; i < PAL_DEPTH; i++) begin
            pal_valid[i]  = 1'b0;
            pal_mirror[i] = '0;
        end
        restart_frame();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_dim_limits();
        test_row_padding();
        test_backpressure();
        test_random_frames(7, 120);
        // final stretch runs without idling on either side
        settle();
        idle_on = 1'b0;
        test_random_frames(1, 150);

        settle();
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/bmpu_pkg.sv
src/bmp_palette_pixel_unpacker.sv
bench/bmp_palette_pixel_unpacker_tb.sv
